// ===== rtl/bcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsc_pkg: shared types and constants of the charge stage controller
// Stage, action and register codes, the per-channel state word and the
// configuration register set with their reset values.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  // Charge stage of one channel
  typedef enum logic [1:0] {
    STAGE_PRECHARGE = 2'd0,
    STAGE_CHARGE    = 2'd1,
    STAGE_FLOAT     = 2'd2,
    STAGE_FAULT     = 2'd3
  } stage_e;

  // Action carried by an input word
  typedef enum logic [1:0] {
    ACT_RESTART  = 2'd0,
    ACT_STAGE    = 2'd1,
    ACT_REGULATE = 2'd2
  } action_e;

  // Configuration register index
  typedef enum logic [2:0] {
    CFG_PRE_WINDOW        = 3'd0,
    CFG_CUT_VOLT          = 3'd1,
    CFG_CHG_VOLT          = 3'd2,
    CFG_FLT_VOLT          = 3'd3,
    CFG_PRECHARGE_CURRENT = 3'd4,
    CFG_BULK_CURRENT      = 3'd5,
    CFG_FLOAT_CURRENT     = 3'd6,
    CFG_TAPER_COUNT_START = 3'd7
  } cfg_idx_e;

  // Taper counter floor and decrement, hold counter ceiling
  localparam logic [15:0]        TAPER_FLOOR  = 16'd10;
  localparam logic [15:0]        TAPER_STEP   = 16'd2;
  localparam logic signed [7:0]  HOLD_CEILING = 8'sd12;

  // Register reset values
  localparam logic [14:0] RST_PRE_WINDOW        = 15'd60;
  localparam logic [14:0] RST_CUT_VOLT          = 15'd10500;
  localparam logic [14:0] RST_CHG_VOLT          = 15'd14400;
  localparam logic [14:0] RST_FLT_VOLT          = 15'd13600;
  localparam logic [14:0] RST_PRECHARGE_CURRENT = 15'd500;
  localparam logic [14:0] RST_BULK_CURRENT      = 15'd5000;
  localparam logic [14:0] RST_FLOAT_CURRENT     = 15'd300;
  localparam logic [15:0] RST_TAPER_COUNT_START = 16'd600;

  // Configuration register set
  typedef struct packed {
    logic [14:0] pre_window;
    logic [14:0] cut_volt;
    logic [14:0] chg_volt;
    logic [14:0] flt_volt;
    logic [14:0] precharge_current;
    logic [14:0] bulk_current;
    logic [14:0] float_current;
    logic [15:0] taper_count_start;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pre_window:        RST_PRE_WINDOW,
    cut_volt:          RST_CUT_VOLT,
    chg_volt:          RST_CHG_VOLT,
    flt_volt:          RST_FLT_VOLT,
    precharge_current: RST_PRECHARGE_CURRENT,
    bulk_current:      RST_BULK_CURRENT,
    float_current:     RST_FLOAT_CURRENT,
    taper_count_start: RST_TAPER_COUNT_START
  };

  // State word of one channel, one memory entry
  typedef struct packed {
    stage_e             stage;
    logic [14:0]        pre_cnt;
    logic [15:0]        taper_cnt;
    logic [14:0]        vref;
    logic [14:0]        iref;
    logic               is_current;
    logic [7:0]         return_cnt;
    logic signed [7:0]  hold_cnt;
  } chan_state_t;

  // State of a channel never written since reset
  localparam chan_state_t STATE_RESET = '{
    stage:      STAGE_PRECHARGE,
    pre_cnt:    RST_PRE_WINDOW,
    taper_cnt:  RST_TAPER_COUNT_START,
    vref:       RST_CHG_VOLT,
    iref:       RST_PRECHARGE_CURRENT,
    is_current: 1'b1,
    return_cnt: 8'd0,
    hold_cnt:   8'sd0
  };

endpackage

// ===== rtl/bcsc_if.sv =====
// ----------------------------------------------------------------------------
// bcsc_if: handshake channels of the charge stage controller
// Measurement word in, status word out, and the register write channel.
// ----------------------------------------------------------------------------
interface bcsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               channel;
  logic signed [15:0] voltage;
  logic signed [15:0] current;

  modport source (output valid, action, channel, voltage, current, input ready);
  modport sink   (input valid, action, channel, voltage, current, output ready);
endinterface

interface bcsc_out_if;
  logic        valid;
  logic        ready;
  logic        channel_out;
  logic [1:0]  stage;
  logic        cc_mode;
  logic [14:0] voltage_setpoint;
  logic [14:0] current_setpoint;

  modport source (output valid, channel_out, stage, cc_mode, voltage_setpoint,
                  current_setpoint, input ready);
  modport sink   (input valid, channel_out, stage, cc_mode, voltage_setpoint,
                  current_setpoint, output ready);
endinterface

interface bcsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/battery_charge_stage_controller_core.sv =====
// ----------------------------------------------------------------------------
// battery_charge_stage_controller_core: per-channel charge stage controller
// Path: the state read is registered with the input word, then the update is registered as the status word.
// Throughput: 1 word per cycle while the output is not stalled, set by the read-modify-write of the
// state memory, with write-back forwarding to a read of the same channel.
// Reset: configuration registers load defaults, channel valid bits clear (reset state).
// ----------------------------------------------------------------------------
module battery_charge_stage_controller_core #(
  parameter int CHANNELS   = 2,
  parameter int HOLD_COUNT = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcsc_in_if.sink           in_i,
  bcsc_out_if.source        out_o,
  bcsc_cfg_if.sink          cfg_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [7:0] HoldNeg    = 8'(0 - HOLD_COUNT);
  localparam logic [7:0]        ReturnLong = 8'(2 * HOLD_COUNT);
  localparam logic [7:0]        ReturnShort = 8'(HOLD_COUNT);

  // Configuration registers
  bcsc_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bcsc_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      case (bcsc_pkg::cfg_idx_e'(cfg_i.index))
        bcsc_pkg::CFG_PRE_WINDOW:        cfg_q.pre_window        <= cfg_i.data[14:0];
        bcsc_pkg::CFG_CUT_VOLT:          cfg_q.cut_volt          <= cfg_i.data[14:0];
        bcsc_pkg::CFG_CHG_VOLT:          cfg_q.chg_volt          <= cfg_i.data[14:0];
        bcsc_pkg::CFG_FLT_VOLT:          cfg_q.flt_volt          <= cfg_i.data[14:0];
        bcsc_pkg::CFG_PRECHARGE_CURRENT: cfg_q.precharge_current <= cfg_i.data[14:0];
        bcsc_pkg::CFG_BULK_CURRENT:      cfg_q.bulk_current      <= cfg_i.data[14:0];
        bcsc_pkg::CFG_FLOAT_CURRENT:     cfg_q.float_current     <= cfg_i.data[14:0];
        bcsc_pkg::CFG_TAPER_COUNT_START: cfg_q.taper_count_start <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              s1_adv;
  logic              in_acc;
  logic [CH_W-1:0]   rd_idx;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign rd_idx     = (CHANNELS > 1) ? CH_W'(in_i.channel) : '0;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the word under update
  logic [1:0]          s1_action_q;
  logic [CH_W-1:0]     s1_chan_q;
  logic signed [15:0]  s1_volt_q;
  logic signed [15:0]  s1_curr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= in_i.action;
      s1_chan_q   <= rd_idx;
      s1_volt_q   <= in_i.voltage;
      s1_curr_q   <= in_i.current;
    end
  end

  // State memory, one entry per channel, registered read
  bcsc_pkg::chan_state_t mem [CHANNELS];
  bcsc_pkg::chan_state_t mem_rd_q;
  bcsc_pkg::chan_state_t fwd_q;
  bcsc_pkg::chan_state_t cur_st;
  bcsc_pkg::chan_state_t nxt_st;
  logic [CHANNELS-1:0]   vld_q;
  logic                  vld_rd_q;
  logic                  byp_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_chan_q] <= nxt_st;
    end
    if (in_acc) begin
      mem_rd_q <= mem[rd_idx];
      fwd_q    <= nxt_st;
    end
  end

  // Track written entries and forward a write-back that meets a new read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (s1_adv) begin
        vld_q[s1_chan_q] <= 1'b1;
      end
      if (in_acc) begin
        vld_rd_q <= vld_q[rd_idx];
        byp_q    <= s1_adv && (s1_chan_q == rd_idx);
      end
    end
  end

  always_comb begin
    if (byp_q) begin
      cur_st = fwd_q;
    end else if (vld_rd_q) begin
      cur_st = mem_rd_q;
    end else begin
      cur_st = bcsc_pkg::STATE_RESET;
    end
  end

  // Apply the action to the channel state
  always_comb begin
    logic signed [15:0] cutoff_s;
    logic signed [15:0] vref_s;
    logic signed [15:0] iref_s;
    logic signed [15:0] fcur_s;
    logic [15:0]        taper_dec;
    logic signed [7:0]  hold_dec;

    cutoff_s  = signed'({1'b0, cfg_q.cut_volt});
    vref_s    = signed'({1'b0, cur_st.vref});
    iref_s    = signed'({1'b0, cur_st.iref});
    fcur_s    = signed'({1'b0, cfg_q.float_current});
    taper_dec = (cur_st.taper_cnt >= bcsc_pkg::TAPER_STEP)
              ? cur_st.taper_cnt - bcsc_pkg::TAPER_STEP : 16'd0;
    hold_dec  = cur_st.hold_cnt - 8'sd1;
    nxt_st    = cur_st;

    case (bcsc_pkg::action_e'(s1_action_q))
      bcsc_pkg::ACT_RESTART: begin
        nxt_st.stage     = bcsc_pkg::STAGE_PRECHARGE;
        nxt_st.pre_cnt   = cfg_q.pre_window;
        nxt_st.iref      = cfg_q.precharge_current;
        nxt_st.vref      = cfg_q.chg_volt;
        nxt_st.taper_cnt = cfg_q.taper_count_start;
      end
      bcsc_pkg::ACT_STAGE: begin
        case (cur_st.stage)
          bcsc_pkg::STAGE_PRECHARGE: begin
            if (s1_volt_q < cutoff_s) begin
              if (cur_st.pre_cnt != 15'd0) begin
                nxt_st.pre_cnt = cur_st.pre_cnt - 15'd1;
              end else begin
                nxt_st.stage = bcsc_pkg::STAGE_FAULT;
              end
            end else begin
              nxt_st.stage = bcsc_pkg::STAGE_CHARGE;
              nxt_st.iref  = cfg_q.bulk_current;
            end
          end
          bcsc_pkg::STAGE_CHARGE: begin
            if (!cur_st.is_current && (s1_curr_q < fcur_s)) begin
              if (taper_dec < bcsc_pkg::TAPER_FLOOR) begin
                nxt_st.stage     = bcsc_pkg::STAGE_FLOAT;
                nxt_st.taper_cnt = bcsc_pkg::TAPER_FLOOR;
              end else begin
                nxt_st.taper_cnt = taper_dec;
              end
            end else if (cur_st.taper_cnt < cfg_q.taper_count_start) begin
              nxt_st.taper_cnt = cur_st.taper_cnt + 16'd1;
            end
          end
          bcsc_pkg::STAGE_FLOAT: begin
            nxt_st.vref = cfg_q.flt_volt;
            nxt_st.iref = cfg_q.float_current;
          end
          default: begin
            nxt_st.is_current = 1'b0;
          end
        endcase
      end
      bcsc_pkg::ACT_REGULATE: begin
        // Voltage hysteresis
        if (s1_volt_q > vref_s) begin
          if (cur_st.hold_cnt < bcsc_pkg::HOLD_CEILING) begin
            nxt_st.hold_cnt = cur_st.hold_cnt + 8'sd1;
          end
          if (cur_st.return_cnt != 8'd0) begin
            nxt_st.return_cnt = cur_st.return_cnt - 8'd1;
          end else begin
            nxt_st.is_current = 1'b0;
          end
        end else if (s1_volt_q < vref_s) begin
          if (hold_dec < HoldNeg) begin
            nxt_st.is_current = 1'b1;
            nxt_st.return_cnt = ReturnLong;
            nxt_st.hold_cnt   = HoldNeg;
          end else begin
            nxt_st.hold_cnt = hold_dec;
          end
        end
        // Drop back from float to charge on a load step
        if ((s1_curr_q > iref_s) && !nxt_st.is_current &&
            (cur_st.stage == bcsc_pkg::STAGE_FLOAT)) begin
          nxt_st.stage      = bcsc_pkg::STAGE_CHARGE;
          nxt_st.vref       = cfg_q.chg_volt;
          nxt_st.iref       = cfg_q.bulk_current;
          nxt_st.is_current = 1'b1;
          nxt_st.return_cnt = ReturnShort;
        end
      end
      default: ;
    endcase
  end

  // Output register
  logic        out_chan_q;
  logic [1:0]  out_stage_q;
  logic        out_mode_q;
  logic [14:0] out_vset_q;
  logic [14:0] out_iset_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q  <= s1_chan_q[0];
      out_stage_q <= nxt_st.stage;
      out_mode_q  <= nxt_st.is_current;
      out_vset_q  <= nxt_st.vref;
      out_iset_q  <= nxt_st.iref;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.channel_out      = out_chan_q;
  assign out_o.stage            = out_stage_q;
  assign out_o.cc_mode          = out_mode_q;
  assign out_o.voltage_setpoint = out_vset_q;
  assign out_o.current_setpoint = out_iset_q;

  // Checks
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (cur_st.stage == bcsc_pkg::STAGE_FAULT) &&
     (s1_action_q != bcsc_pkg::ACT_RESTART)) |-> (nxt_st.stage == bcsc_pkg::STAGE_FAULT))
    else $error("fault stage left without restart");

  a_fault_voltage_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (cur_st.stage == bcsc_pkg::STAGE_FAULT) &&
     (s1_action_q == bcsc_pkg::ACT_STAGE)) |-> !nxt_st.is_current)
    else $error("stage step in fault kept current mode");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline slot");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("updated word did not reach the output register");

endmodule
